// ===== design/amt_pkg.sv =====
// Shared types and constants of the adaptive median threshold unit.
// No dependencies; compiled first.
package amt_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [4:0] WIN_PRE_RST  = 5'd8;
	localparam logic [4:0] WIN_POST_RST = 5'd7;
	localparam logic       POS_ONLY_RST = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIN_PRE  = 2'd0,
		REG_WIN_POST = 2'd1,
		REG_POS_ONLY = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CH_HOLD   = 2'd0,
		CH_CLEAR  = 2'd1,
		CH_INSERT = 2'd2,
		CH_SHIFT  = 2'd3
	} chain_mode_t;

endpackage

// ===== design/amt_if.sv =====
// Channel interfaces: sample requests, result requests, configuration writes.
// Depends on amt_pkg.
interface amt_sample_if #(parameter int W = 24);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample;
	logic                frame_end;

	modport source (output valid, output sample, output frame_end, input ready);
	modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface amt_result_if #(parameter int W = 24);
	logic              valid;
	logic              ready;
	logic signed [W:0] residual;
	logic              frame_last;

	modport source (output valid, output residual, output frame_last, input ready);
	modport sink   (input valid, input residual, input frame_last, output ready);
endinterface

interface amt_cfg_if;
	import amt_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/adaptive_median_threshold_unit.sv =====
// Adaptive median threshold: top level with ring history, sequencer and output register.
// Depends on amt_pkg, amt_if (channel interfaces) and amt_chain.
//
// Usage:
//   samples : sample requests (sample, frame_end); accepted when valid && ready.
//   results : result requests (residual, frame_last) from a single output register.
//   cfg     : register writes (index, data), always ready; write only while idle.
// Each accepted sample is stored in a ring; results for earlier samples follow once
// win_post later samples exist, and frame_end drains all outstanding ones.
// For one result, n = clipped window size (up to win_pre + win_post + 1) and
// lo = floor((n-1)/2): the window is read from the ring one sample per cycle into the
// sorted cell chain, then shifted lo places toward the head.
// A sample that causes no result returns to idle through the check step.
// The sample channel is ready only in idle; a waiting result does not block it, but a
// stalled receiver holds the next result in its emit step until the register frees.
// Reset: window 8 before / 7 after, positive_only set, ring empty, no outstanding
// results; no clearing pass is needed.
module adaptive_median_threshold_unit #(
	parameter int MAX_PRE     = 31,
	parameter int MAX_POST    = 31,
	parameter int SAMPLE_BITS = 24
) (
	input  logic     clk,
	input  logic     arst_n,
	amt_sample_if.sink samples,
	amt_result_if.source results,
	amt_cfg_if.sink  cfg
);
	import amt_pkg::*;

	localparam int W        = SAMPLE_BITS;
	localparam int D        = MAX_PRE + MAX_POST + 2;
	localparam int WIN      = MAX_PRE + MAX_POST + 1;
	localparam int FILL_CAP = D + MAX_PRE;
	localparam int AW       = $clog2(D);
	localparam int PW       = $clog2(MAX_POST + 2);
	localparam int FW       = $clog2(FILL_CAP + 1);
	localparam int NW       = $clog2(WIN + 1);
	localparam int BW       = $clog2(MAX_PRE + 1);
	localparam int AB       = $clog2(MAX_POST + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_LOAD, S_SHIFT, S_MED, S_EMIT
	} state_t;

	state_t state_q;

	logic [4:0] win_pre_q;
	logic [4:0] win_post_q;
	logic       pos_only_q;

	logic signed [W-1:0] hist [D];
	logic signed [W-1:0] rd_data_s1;
	logic [AW-1:0]       rd_addr_q;
	logic                rd_vld_s1;
	logic [NW-1:0]       rd_k_s1;

	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] emit_q;
	logic [PW-1:0] pending_q;
	logic [FW-1:0] fill_q;
	logic          drain_q;

	logic [BW-1:0] below_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] k_q;
	logic [NW-1:0] sh_q;

	logic signed [W-1:0] center_q;
	logic signed [W-1:0] med_q;

	logic              res_valid_q;
	logic signed [W:0] res_residual_q;
	logic              res_last_q;

	logic                take;
	logic [BW-1:0]       pre_eff;
	logic [AB-1:0]       post_eff;
	logic [FW-1:0]       done;
	logic [BW-1:0]       below;
	logic [PW-1:0]       pm1;
	logic [AB-1:0]       above;
	logic [NW-1:0]       n_w;
	logic [AW:0]         start_w;
	logic [NW-1:0]       lo_w;
	logic                go;
	logic signed [W-1:0] head0;
	logic signed [W-1:0] head1;
	logic signed [W:0]   sum_w;
	logic signed [W:0]   diff_w;
	chain_mode_t         mode;

	assign take          = samples.valid && samples.ready;
	assign samples.ready = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;

	assign results.valid      = res_valid_q;
	assign results.residual   = res_residual_q;
	assign results.frame_last = res_last_q;

	// window bounds for the sample at emit_q
	assign pre_eff  = (32'(win_pre_q) < MAX_PRE) ? BW'(win_pre_q) : BW'(MAX_PRE);
	assign post_eff = (32'(win_post_q) < MAX_POST) ? AB'(win_post_q) : AB'(MAX_POST);
	assign done     = fill_q - FW'(pending_q);
	assign below    = (32'(done) < 32'(pre_eff)) ? BW'(done) : pre_eff;
	assign pm1      = pending_q - PW'(1);
	assign above    = (32'(pm1) < 32'(post_eff)) ? AB'(pm1) : post_eff;
	assign n_w      = NW'(below) + NW'(above) + NW'(1);
	assign start_w  = (32'(emit_q) >= 32'(below))
		? ((AW+1)'(emit_q) - (AW+1)'(below))
		: ((AW+1)'(emit_q) + (AW+1)'(D) - (AW+1)'(below));
	assign lo_w     = n_q[0] ? (n_q >> 1) : ((n_q >> 1) - NW'(1));
	assign go       = drain_q ? (pending_q != '0) : (32'(pending_q) > 32'(post_eff));

	assign sum_w  = {head0[W-1], head0} + {head1[W-1], head1};
	assign diff_w = {center_q[W-1], center_q} - {med_q[W-1], med_q};

	always_comb begin
		case (state_q)
			S_CHECK: mode = CH_CLEAR;
			S_LOAD:  mode = rd_vld_s1 ? CH_INSERT : CH_HOLD;
			S_SHIFT: mode = (sh_q != '0) ? CH_SHIFT : CH_HOLD;
			default: mode = CH_HOLD;
		endcase
	end

	amt_chain #(.W(W), .DEPTH(WIN)) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode),
		.ins_value (rd_data_s1),
		.head0     (head0),
		.head1     (head1)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			hist[wr_ptr_q] <= samples.sample;
		end
		rd_data_s1 <= hist[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_pre_q  <= WIN_PRE_RST;
			win_post_q <= WIN_POST_RST;
			pos_only_q <= POS_ONLY_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WIN_PRE:  win_pre_q  <= cfg.data[4:0];
				REG_WIN_POST: win_post_q <= cfg.data[4:0];
				REG_POS_ONLY: pos_only_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			wr_ptr_q       <= '0;
			emit_q         <= '0;
			pending_q      <= '0;
			fill_q         <= '0;
			drain_q        <= 1'b0;
			rd_addr_q      <= '0;
			rd_vld_s1      <= 1'b0;
			rd_k_s1        <= '0;
			below_q        <= '0;
			n_q            <= '0;
			k_q            <= '0;
			sh_q           <= '0;
			center_q       <= '0;
			med_q          <= '0;
			res_valid_q    <= 1'b0;
			res_residual_q <= '0;
			res_last_q     <= 1'b0;
		end else begin
			if (results.ready && (state_q != S_EMIT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						wr_ptr_q  <= (32'(wr_ptr_q) == D - 1) ? '0 : wr_ptr_q + AW'(1);
						pending_q <= pending_q + PW'(1);
						if (32'(fill_q) < FILL_CAP) begin
							fill_q <= fill_q + FW'(1);
						end
						drain_q <= samples.frame_end;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					rd_vld_s1 <= 1'b0;
					if (go) begin
						below_q   <= below;
						n_q       <= n_w;
						k_q       <= '0;
						rd_addr_q <= AW'(start_w);
						state_q   <= S_LOAD;
					end else begin
						if (drain_q) begin
							fill_q  <= '0;
							drain_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				S_LOAD: begin
					if (rd_vld_s1 && (rd_k_s1 == NW'(below_q))) begin
						center_q <= rd_data_s1;
					end
					if (k_q != n_q) begin
						rd_vld_s1 <= 1'b1;
						rd_k_s1   <= k_q;
						k_q       <= k_q + NW'(1);
						rd_addr_q <= (32'(rd_addr_q) == D - 1) ? '0 : rd_addr_q + AW'(1);
					end else begin
						rd_vld_s1 <= 1'b0;
						sh_q      <= lo_w;
						state_q   <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (sh_q != '0) begin
						sh_q <= sh_q - NW'(1);
					end else begin
						state_q <= S_MED;
					end
				end
				S_MED: begin
					med_q   <= n_q[0] ? head0 : sum_w[W:1];
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!res_valid_q || results.ready) begin
						res_valid_q    <= 1'b1;
						res_residual_q <= (pos_only_q && diff_w[W]) ? '0 : diff_w;
						res_last_q     <= drain_q && (pending_q == PW'(1));
						emit_q         <= (32'(emit_q) == D - 1) ? '0 : emit_q + AW'(1);
						pending_q      <= pending_q - PW'(1);
						state_q        <= S_CHECK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pending_q) <= MAX_POST + 1)
		else $error("outstanding count beyond window");

	a_ring_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wr_ptr_q) == ((32'(emit_q) + 32'(pending_q)) % D))
		else $error("ring pointers out of step");

	a_fill_covers: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) >= 32'(pending_q))
		else $error("fill count below outstanding count");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result raised outside emit step");
`endif

endmodule

// ===== design/amt_cell.sv =====
// One cell of the sorting chain: holds one value; clears, inserts or shifts with neighbors.
// Depends on amt_pkg.
module amt_cell #(
	parameter int W = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  amt_pkg::chain_mode_t mode,
	input  logic signed [W-1:0] ins_value,
	input  logic signed [W-1:0] left_value,
	input  logic                left_valid,
	input  logic                left_stop,
	input  logic signed [W-1:0] right_value,
	input  logic                right_valid,
	output logic signed [W-1:0] value,
	output logic                valid,
	output logic                stop
);
	import amt_pkg::*;

	logic signed [W-1:0] value_q;
	logic                valid_q;

	// first cell holding a larger value or empty marks the insert point
	assign stop  = !valid_q || (value_q > ins_value);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (mode)
				CH_CLEAR: valid_q <= 1'b0;
				CH_INSERT: begin
					if (left_stop) begin
						valid_q <= left_valid;
					end else if (stop) begin
						valid_q <= 1'b1;
					end
				end
				CH_SHIFT: valid_q <= right_valid;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (mode)
			CH_INSERT: begin
				if (left_stop) begin
					value_q <= left_value;
				end else if (stop) begin
					value_q <= ins_value;
				end
			end
			CH_SHIFT: value_q <= right_value;
			default: value_q <= value_q;
		endcase
	end

endmodule

// ===== design/amt_chain.sv =====
// Row of sorting cells kept in ascending order; head cells feed median pick.
// Depends on amt_pkg and amt_cell.
module amt_chain #(
	parameter int W     = 24,
	parameter int DEPTH = 63
) (
	input  logic                clk,
	input  logic                arst_n,
	input  amt_pkg::chain_mode_t mode,
	input  logic signed [W-1:0] ins_value,
	output logic signed [W-1:0] head0,
	output logic signed [W-1:0] head1
);
	import amt_pkg::*;

	logic signed [W-1:0] val [DEPTH];
	logic [DEPTH-1:0]    vld;
	logic [DEPTH-1:0]    stp;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [W-1:0] lv;
		logic                lvld;
		logic                lstp;
		logic signed [W-1:0] rv;
		logic                rvld;

		if (i == 0) begin : g_first
			assign lv   = '0;
			assign lvld = 1'b0;
			assign lstp = 1'b0;
		end else begin : g_mid_l
			assign lv   = val[i-1];
			assign lvld = vld[i-1];
			assign lstp = stp[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rv   = '0;
			assign rvld = 1'b0;
		end else begin : g_mid_r
			assign rv   = val[i+1];
			assign rvld = vld[i+1];
		end

		amt_cell #(.W(W)) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.mode        (mode),
			.ins_value   (ins_value),
			.left_value  (lv),
			.left_valid  (lvld),
			.left_stop   (lstp),
			.right_value (rv),
			.right_valid (rvld),
			.value       (val[i]),
			.valid       (vld[i]),
			.stop        (stp[i])
		);
	end

	assign head0 = val[0];
	assign head1 = val[1];

`ifndef SYNTHESIS
	// occupied cells form a run starting at the head
	a_valid_run: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, vld} + {{DEPTH{1'b0}}, 1'b1}))
		else $error("chain occupancy not contiguous");

	for (genvar j = 0; j < DEPTH - 1; j++) begin : g_ord
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			vld[j+1] |-> (val[j] <= val[j+1]))
			else $error("chain out of order");
	end
`endif

endmodule
